// File: hw/rtl/ssrch_pkg.sv
// Package for the stream signature search block: widths, command, status and
// register index codes shared by the RTL.
// No dependencies.
package ssrch_pkg;

  // Window depth and the width of a reported start offset
  localparam int MAX_SIGNATURE = 16;
  localparam int OFFSET_WIDTH  = 48;

  // Derived widths
  localparam int SEEN_W      = OFFSET_WIDTH + 1;
  localparam int LEN_W       = $clog2(MAX_SIGNATURE + 1);
  localparam int IDX_W       = $clog2(MAX_SIGNATURE);
  localparam int OUT_TDATA_W = ((OFFSET_WIDTH + 7) / 8) * 8;
  localparam int IN_TDATA_W  = 8;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int SIG_LEN_W   = 5;

  // Input transaction kinds, carried on in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_DATA  = 2'd0,
    CMD_EOS   = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  // Result kinds, carried on out_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_MATCH = 2'd0,
    ST_EOS   = 2'd1,
    ST_LIMIT = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIG_LO    = 3'd0,
    REG_SIG_HI    = 3'd1,
    REG_SIG_LEN   = 3'd2,
    REG_LIMIT_EN  = 3'd3,
    REG_START_LIM = 3'd4
  } cfg_reg_t;

endpackage

// File: hw/rtl/stream_signature_search.sv
// Stream signature search: top level, a single-pass registered datapath.
// Depends on ssrch_pkg.
//
// Usage:
//   in_*  : byte stream. in_tuser is the transaction kind (data byte, end of
//           stream, start new search), in_tdata the byte.
//   out_* : one result per search. out_tuser is the status (match, end of
//           stream before match, limit exceeded), out_tdata the match start
//           offset (zero unless the status is match).
//   cfg_* : register writes, index on cfg_index, value on cfg_data; always
//           ready. Write only while no transaction is in flight.
// Timing: an accepted transaction is latched in an input register; when it
//   fires it updates the window, byte counter and done flag, and any
//   result is loaded into the output register. A result therefore passes
//   the input register and then the output register. One input transaction
//   is taken every cycle while the output does not stall; the whole window
//   compare is combinational on the registered byte.
// Stalls: while out_tvalid is high and out_tready low, the held input stays
//   in its register and in_tready drops once that register is occupied;
//   nothing is lost.
// Reset: synchronous, rst_n low. Configuration and state registers return to
//   their defaults, the window and counter clear and a new search is active.
module stream_signature_search (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // in_tdata: [7:0] data_byte
  input  logic [ssrch_pkg::IN_TDATA_W-1:0]         in_tdata,
  // in_tuser: [1:0] command
  input  logic [ssrch_pkg::CMD_W-1:0]              in_tuser,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // out_tdata: [OFFSET_WIDTH-1:0] match_offset, zero padded to whole bytes
  output logic [ssrch_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // out_tuser: [1:0] status
  output logic [ssrch_pkg::STATUS_W-1:0]           out_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [ssrch_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ssrch_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import ssrch_pkg::*;

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  // Configuration registers
  logic [CFG_DATA_W-1:0]   sig_lo_r;
  logic [CFG_DATA_W-1:0]   sig_hi_r;
  logic [SIG_LEN_W-1:0]    sig_len_r;
  logic                    lim_en_r;
  logic [OFFSET_WIDTH-1:0] start_lim_r;

  // Input register
  logic                    in_valid_r;
  cmd_t                    in_cmd_r;
  logic [7:0]              in_byte_r;

  // Search state
  logic [7:0]              win_r [MAX_SIGNATURE];
  logic [7:0]              win_nxt [MAX_SIGNATURE];
  logic [SEEN_W-1:0]       seen_r;
  logic [SEEN_W-1:0]       seen_nxt;
  logic                    done_r;
  logic                    done_nxt;

  // Result register
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  status_t                 out_status_r;
  status_t                 out_status_nxt;
  logic [OFFSET_WIDTH-1:0] out_offset_r;
  logic [OFFSET_WIDTH-1:0] out_offset_nxt;

  // Datapath
  logic                    fire;
  logic                    res_valid;
  status_t                 res_status;
  logic [OFFSET_WIDTH-1:0] res_offset;
  logic [LEN_W-1:0]        len_use;
  logic [2*CFG_DATA_W-1:0] sig_all;
  logic [7:0]              sig_byte [MAX_SIGNATURE];
  logic [LEN_W:0]          pos_sum [MAX_SIGNATURE];
  logic [7:0]              win_shift [MAX_SIGNATURE];
  logic [SEEN_W-1:0]       seen_inc;
  logic [SEEN_W-1:0]       cand;
  logic                    have_cand;
  logic                    limit_hit;
  logic                    hit;

  // Handshakes: the input register drains whenever the result slot is free
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_lo_r    <= '0;
      sig_hi_r    <= '0;
      sig_len_r   <= SIG_LEN_W'(1);
      lim_en_r    <= 1'b0;
      start_lim_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIG_LO:    sig_lo_r    <= cfg_data;
        REG_SIG_HI:    sig_hi_r    <= cfg_data;
        REG_SIG_LEN:   sig_len_r   <= cfg_data[SIG_LEN_W-1:0];
        REG_LIMIT_EN:  lim_en_r    <= cfg_data[0];
        REG_START_LIM: start_lim_r <= cfg_data[OFFSET_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register: load on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= cmd_t'(in_tuser);
      in_byte_r <= in_tdata;
    end
  end

  // Clamp the length to one through the window depth
  always_comb begin
    if (sig_len_r == '0) begin
      len_use = LEN_W'(1);
    end else if (LEN_W'(sig_len_r) > LEN_W'(MAX_SIGNATURE)) begin
      len_use = LEN_W'(MAX_SIGNATURE);
    end else begin
      len_use = LEN_W'(sig_len_r);
    end
  end

  // Signature bytes, window shifted by the new byte, and the alignment of
  // each window slot against the signature
  always_comb begin
    sig_all = {sig_hi_r, sig_lo_r};
    for (int j = 0; j < MAX_SIGNATURE; j++) begin
      sig_byte[j] = sig_all[8*j +: 8];
      pos_sum[j]  = (LEN_W+1)'(j) + (LEN_W+1)'(len_use);
      if (j == MAX_SIGNATURE - 1) begin
        win_shift[j] = in_byte_r;
      end else begin
        win_shift[j] = win_r[j+1];
      end
    end
  end

  // Compare the newest len_use window bytes against the signature
  always_comb begin
    logic [LEN_W:0] sel;
    hit = 1'b1;
    for (int j = 0; j < MAX_SIGNATURE; j++) begin
      sel = pos_sum[j] - (LEN_W+1)'(MAX_SIGNATURE);
      if (pos_sum[j] >= (LEN_W+1)'(MAX_SIGNATURE)) begin
        if (win_shift[j] != sig_byte[sel[IDX_W-1:0]]) begin
          hit = 1'b0;
        end
      end
    end
  end

  // Byte count, candidate start offset and limit check
  always_comb begin
    seen_inc  = (seen_r == SEEN_MAX) ? seen_r : seen_r + SEEN_W'(1);
    have_cand = seen_inc >= SEEN_W'(len_use);
    cand      = seen_inc - SEEN_W'(len_use);
    limit_hit = cand[SEEN_W-1] ||
                (lim_en_r && (cand[OFFSET_WIDTH-1:0] > start_lim_r));
  end

  // Next search state and the result of the held transaction
  always_comb begin
    win_nxt    = win_r;
    seen_nxt   = seen_r;
    done_nxt   = done_r;
    res_valid  = 1'b0;
    res_status = ST_MATCH;
    res_offset = '0;
    if (fire) begin
      case (in_cmd_r)
        CMD_START: begin
          for (int j = 0; j < MAX_SIGNATURE; j++) begin
            win_nxt[j] = '0;
          end
          seen_nxt = '0;
          done_nxt = 1'b0;
        end
        CMD_EOS: begin
          if (!done_r) begin
            done_nxt   = 1'b1;
            res_valid  = 1'b1;
            res_status = ST_EOS;
          end
        end
        CMD_DATA: begin
          if (!done_r) begin
            win_nxt  = win_shift;
            seen_nxt = seen_inc;
            if (have_cand) begin
              if (limit_hit) begin
                done_nxt   = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_LIMIT;
              end else if (hit) begin
                done_nxt   = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_MATCH;
                res_offset = cand[OFFSET_WIDTH-1:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result slot: load a new result, else drop the old one once taken
  always_comb begin
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    if (res_valid) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_offset_nxt = res_offset;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  // Search state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_SIGNATURE; j++) begin
        win_r[j] <= '0;
      end
      seen_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      seen_r      <= seen_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'(out_offset_r);

  // A result only appears after a transaction was processed
  a_res_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire))
    else $error("result appeared without a processed transaction");

  // Every result closes the search
  a_res_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid) |=> done_r)
    else $error("search not closed after a result");

  // A closed search ignores everything but a new search command
  a_done_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && fire && in_cmd_r != CMD_START) |=> ($stable(seen_r) && done_r))
    else $error("closed search changed state");

  // Offset is only reported with a match
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_MATCH) |-> (out_offset_r == '0))
    else $error("non-zero offset without a match");

endmodule
